>>> hdl/udpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP port demultiplexer package
// Item kinds, result status codes, controller states and command types.
// ----------------------------------------------------------------------------
package udpd_pkg;

  localparam int DEF_NUM_SLOTS = 64;
  localparam int DEF_BUF_BYTES = 4096;
  localparam int HDR_BYTES     = 8;

  typedef enum logic [2:0] {
    KIND_BIND   = 3'd0,
    KIND_UNBIND = 3'd1,
    KIND_HEADER = 3'd2,
    KIND_DATA   = 3'd3,
    KIND_RECV   = 3'd4,
    KIND_READ   = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_FREE   = 3'd1,
    ST_NOT_READY = 3'd2,
    ST_NO_MATCH  = 3'd3,
    ST_SHORT     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic commit;
  } ctrl_cmd_t;

endpackage

>>> hdl/udpd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module udpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/udpd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP port demultiplexer controller
// Sequences each transaction through capture, evaluation and commit.
// ----------------------------------------------------------------------------
module udpd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output udpd_pkg::ctrl_cmd_t cmd
);
  import udpd_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.commit = 1'b1;
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe outside a transaction");
  a_done_free: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("block stays busy after a result");
  a_accept: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy && !done)
    else $error("accepted transaction not in evaluation");

endmodule

>>> hdl/udpd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP port demultiplexer datapath
// Slot table, match vectors, delivery state and the metadata and buffer RAMs.
// ----------------------------------------------------------------------------
module udpd_dp #(
  parameter int NUM_SLOTS = udpd_pkg::DEF_NUM_SLOTS,
  parameter int BUF_BYTES = udpd_pkg::DEF_BUF_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  udpd_pkg::ctrl_cmd_t cmd,
  input  logic [2:0]          kind,
  input  logic [15:0]         bind_port,
  input  logic [5:0]          slot,
  input  logic [15:0]         dest_port,
  input  logic [15:0]         source_port,
  input  logic [31:0]         source_ip,
  input  logic [15:0]         udp_length,
  input  logic [15:0]         frame_length,
  input  logic [7:0]          data_byte,
  input  logic [15:0]         max_len,
  input  logic [11:0]         byte_offset,
  output logic [2:0]          status,
  output logic [5:0]          result_slot,
  output logic [12:0]         count,
  output logic [31:0]         sender_ip,
  output logic [15:0]         sender_port,
  output logic [7:0]          read_byte
);
  import udpd_pkg::*;

  localparam int SW    = $clog2(NUM_SLOTS);
  localparam int LW    = $clog2(BUF_BYTES + 1);
  localparam int MW    = LW + 48;
  localparam int BDEP  = NUM_SLOTS * BUF_BYTES;
  localparam int AW    = $clog2(BDEP);
  localparam logic [16:0] BUF_LIM = 17'(BUF_BYTES);

  kind_t       kind_q;
  logic [15:0] bind_port_q, dest_port_q, source_port_q, udp_length_q, frame_length_q, max_len_q;
  logic [5:0]  slot_q;
  logic [31:0] source_ip_q;
  logic [7:0]  data_byte_q;
  logic [11:0] byte_offset_q;

  logic [NUM_SLOTS-1:0] slot_bound, slot_ready, free_vec, match_vec;
  logic [15:0]          slot_port [NUM_SLOTS];

  logic [SW-1:0] dly_slot;
  logic          dly_active;
  logic [LW-1:0] dly_offset, dly_limit;

  logic [SW-1:0] free_idx, match_idx, sidx;
  logic          any_free, any_match, slot_ok, off_ok, short_frame, recv_ok;
  logic [15:0]   plen;
  logic [LW-1:0] copy_len;

  logic          meta_we, buf_we;
  logic [MW-1:0] meta_wdata, meta_rdata;
  logic [AW-1:0] buf_waddr, buf_raddr;
  logic [7:0]    buf_rdata;
  logic [LW-1:0] rd_len;
  logic [16:0]   cnt_full;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q         <= kind_t'(kind);
      bind_port_q    <= bind_port;
      slot_q         <= slot;
      dest_port_q    <= dest_port;
      source_port_q  <= source_port;
      source_ip_q    <= source_ip;
      udp_length_q   <= udp_length;
      frame_length_q <= frame_length;
      data_byte_q    <= data_byte;
      max_len_q      <= max_len;
      byte_offset_q  <= byte_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        free_vec[i]  <= !slot_bound[i];
        match_vec[i] <= slot_bound[i] && (slot_port[i] == dest_port_q);
      end
    end
  end

  always_comb begin
    free_idx  = '0;
    match_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_idx = SW'(i);
      end
      if (match_vec[i]) begin
        match_idx = SW'(i);
      end
    end
    any_free    = |free_vec;
    any_match   = |match_vec;
    sidx        = SW'(slot_q);
    slot_ok     = 32'(slot_q) < NUM_SLOTS;
    off_ok      = 32'(byte_offset_q) < BUF_BYTES;
    short_frame = frame_length_q < 16'(HDR_BYTES);
    plen        = udp_length_q - 16'(HDR_BYTES);
    copy_len    = ({1'b0, plen} < BUF_LIM) ? LW'(plen) : LW'(BUF_LIM);
    recv_ok     = slot_ok && slot_bound[sidx] && slot_ready[sidx];
  end

  assign meta_we    = cmd.commit && kind_q == KIND_HEADER && !short_frame && any_match;
  assign meta_wdata = {copy_len, source_ip_q, source_port_q};
  assign buf_we     = cmd.commit && kind_q == KIND_DATA && dly_active && dly_offset < dly_limit;
  assign buf_waddr  = AW'(dly_slot) * AW'(BUF_BYTES) + AW'(dly_offset);
  assign buf_raddr  = AW'(sidx) * AW'(BUF_BYTES) + AW'(byte_offset_q);

  udpd_ram #(.WIDTH(MW), .DEPTH(NUM_SLOTS)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (match_idx),
    .wdata (meta_wdata),
    .raddr (sidx),
    .rdata (meta_rdata)
  );

  udpd_ram #(.WIDTH(8), .DEPTH(BDEP)) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (data_byte_q),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_bound <= '0;
      slot_ready <= '0;
      dly_slot   <= '0;
      dly_active <= 1'b0;
      dly_offset <= '0;
      dly_limit  <= '0;
    end else if (cmd.commit) begin
      case (kind_q)
        KIND_BIND: begin
          if (any_free) begin
            slot_bound[free_idx] <= 1'b1;
            slot_ready[free_idx] <= 1'b0;
            slot_port[free_idx]  <= bind_port_q;
          end
        end
        KIND_UNBIND: begin
          if (slot_ok) begin
            slot_bound[sidx] <= 1'b0;
          end
        end
        KIND_HEADER: begin
          dly_active <= !short_frame && any_match && copy_len != '0;
          if (!short_frame && any_match) begin
            slot_ready[match_idx] <= 1'b1;
            dly_slot   <= match_idx;
            dly_offset <= '0;
            dly_limit  <= copy_len;
          end
        end
        KIND_DATA: begin
          if (buf_we) begin
            dly_offset <= dly_offset + 1'b1;
            dly_active <= (dly_offset + 1'b1) < dly_limit;
          end else begin
            dly_active <= 1'b0;
          end
        end
        KIND_RECV: begin
          if (recv_ok) begin
            slot_ready[sidx] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    status      = ST_OK;
    result_slot = '0;
    count       = '0;
    sender_ip   = '0;
    sender_port = '0;
    read_byte   = '0;
    rd_len      = meta_rdata[MW-1 -: LW];
    cnt_full    = (17'(rd_len) < {1'b0, max_len_q}) ? 17'(rd_len) : {1'b0, max_len_q};
    case (kind_q)
      KIND_BIND: begin
        if (any_free) begin
          result_slot = 6'(free_idx);
        end else begin
          status = ST_NO_FREE;
        end
      end
      KIND_UNBIND: begin
        if (!slot_ok) begin
          status = ST_NOT_READY;
        end
      end
      KIND_HEADER: begin
        if (short_frame) begin
          status = ST_SHORT;
        end else if (any_match) begin
          result_slot = 6'(match_idx);
        end else begin
          status = ST_NO_MATCH;
        end
      end
      KIND_RECV: begin
        if (recv_ok) begin
          count       = 13'(cnt_full);
          sender_ip   = meta_rdata[47:16];
          sender_port = meta_rdata[15:0];
        end else begin
          status = ST_NOT_READY;
        end
      end
      KIND_READ: begin
        if (slot_ok && off_ok) begin
          read_byte = buf_rdata;
        end else begin
          status = ST_NOT_READY;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hdl/udp_port_demux_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP port demultiplexer table
// Receive slot table that binds ports, steers datagrams and returns payload.
// ----------------------------------------------------------------------------
// Each transaction is accepted when start is high and busy is low; busy then
// stays high through the evaluation and done states, and the result appears for
// exactly one cycle with done high; the next start is taken in the cycle after
// done. The sequence is set by the registered match and free vectors over the
// slot table and by the registered read of the metadata and buffer RAMs. The
// receiver cannot stall, so results must be captured when done is high. The
// buffer RAM has no clearing pass and is usable directly after reset.
module udp_port_demux_table_unit #(
  parameter int NUM_SLOTS = udpd_pkg::DEF_NUM_SLOTS,
  parameter int BUF_BYTES = udpd_pkg::DEF_BUF_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [2:0]  kind,
  input  logic [15:0] bind_port,
  input  logic [5:0]  slot,
  input  logic [15:0] dest_port,
  input  logic [15:0] source_port,
  input  logic [31:0] source_ip,
  input  logic [15:0] udp_length,
  input  logic [15:0] frame_length,
  input  logic [7:0]  data_byte,
  input  logic [15:0] max_len,
  input  logic [11:0] byte_offset,
  output logic [2:0]  status,
  output logic [5:0]  result_slot,
  output logic [12:0] count,
  output logic [31:0] sender_ip,
  output logic [15:0] sender_port,
  output logic [7:0]  read_byte
);
  import udpd_pkg::*;

  ctrl_cmd_t cmd;

  udpd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  udpd_dp #(.NUM_SLOTS(NUM_SLOTS), .BUF_BYTES(BUF_BYTES)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .kind         (kind),
    .bind_port    (bind_port),
    .slot         (slot),
    .dest_port    (dest_port),
    .source_port  (source_port),
    .source_ip    (source_ip),
    .udp_length   (udp_length),
    .frame_length (frame_length),
    .data_byte    (data_byte),
    .max_len      (max_len),
    .byte_offset  (byte_offset),
    .status       (status),
    .result_slot  (result_slot),
    .count        (count),
    .sender_ip    (sender_ip),
    .sender_port  (sender_port),
    .read_byte    (read_byte)
  );

endmodule
